[design/tmq_pkg.sv]
// Shared types, constants and status codes of the typed message queue.
package tmq_pkg;

  localparam int MAX_MESSAGES_DEFAULT = 64;
  localparam logic [15:0] QUEUE_BYTE_LIMIT_RESET = 16'd16384;
  localparam logic [15:0] MAX_MESSAGE_SIZE_RESET = 16'd4056;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_NOSPACE = 3'd2;
  localparam logic [2:0] ST_NOMSG   = 3'd3;
  localparam logic [2:0] ST_TOOBIG  = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;

  localparam logic OP_SEND    = 1'b0;
  localparam logic OP_RECEIVE = 1'b1;

  localparam logic REG_QUEUE_BYTE_LIMIT = 1'b0;
  localparam logic REG_MAX_MESSAGE_SIZE = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] type_value;
    logic [15:0]        byte_size;
    logic [31:0]        payload_tag;
    logic               except_mode;
    logic               no_error;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] length;
    logic [30:0] taken_type;
    logic [31:0] taken_tag;
    logic [6:0]  message_count;
    logic [15:0] bytes_held;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init;
    logic load;
    logic s_check;
    logic s_wr1;
    logic s_wr2;
    logic r_start;
    logic r_scan;
    logic r_decide;
    logic r_free;
  } tmq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic init_last;
    logic opcode;
    logic send_bad;
    logic empty;
    logic scan_last;
    logic rx_bad;
  } tmq_stat_t;

endpackage

[design/tmq_ctrl.sv]
// Controller state machine of the typed message queue.
module tmq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  output logic             done,
  output tmq_pkg::tmq_cmd_t cmd,
  input  tmq_pkg::tmq_stat_t stat
);
  import tmq_pkg::*;

  localparam logic [3:0] S_INIT     = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_SCHECK   = 4'd2;
  localparam logic [3:0] S_SWR1     = 4'd3;
  localparam logic [3:0] S_SWR2     = 4'd4;
  localparam logic [3:0] S_RSTART   = 4'd5;
  localparam logic [3:0] S_RSCAN    = 4'd6;
  localparam logic [3:0] S_RDECIDE  = 4'd7;
  localparam logic [3:0] S_RFREE    = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_INIT: begin
        cmd.init = 1'b1;
        if (stat.init_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_SCHECK;
        end
      end
      S_SCHECK: begin
        // request is latched by now; branch on its opcode
        if (stat.opcode == OP_RECEIVE) begin
          state_next = S_RSTART;
        end else begin
          cmd.s_check = 1'b1;
          state_next = stat.send_bad ? S_DONE : S_SWR1;
        end
      end
      S_SWR1: begin
        cmd.s_wr1 = 1'b1;
        state_next = S_SWR2;
      end
      S_SWR2: begin
        cmd.s_wr2 = 1'b1;
        state_next = S_DONE;
      end
      S_RSTART: begin
        cmd.r_start = 1'b1;
        state_next = stat.empty ? S_DONE : S_RSCAN;
      end
      S_RSCAN: begin
        cmd.r_scan = 1'b1;
        if (stat.scan_last) state_next = S_RDECIDE;
      end
      S_RDECIDE: begin
        cmd.r_decide = 1'b1;
        state_next = stat.rx_bad ? S_DONE : S_RFREE;
      end
      S_RFREE: begin
        cmd.r_free = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

[design/tmq_datapath.sv]
// Descriptor stores, linked lists, counters and result register of the queue.
module tmq_datapath #(
  parameter int MAX_MESSAGES = tmq_pkg::MAX_MESSAGES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  tmq_pkg::req_t      request,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  input  tmq_pkg::tmq_cmd_t  cmd,
  output tmq_pkg::tmq_stat_t stat,
  output tmq_pkg::result_t   result
);
  import tmq_pkg::*;

  localparam int SW = $clog2(MAX_MESSAGES);
  localparam int CW = $clog2(MAX_MESSAGES + 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_MESSAGES - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_MESSAGES);

  logic [30:0]   type_mem [MAX_MESSAGES];
  logic [15:0]   size_mem [MAX_MESSAGES];
  logic [31:0]   tag_mem  [MAX_MESSAGES];
  logic [SW-1:0] link_mem [MAX_MESSAGES];

  logic [30:0]   rd_type;
  logic [15:0]   rd_size;
  logic [31:0]   rd_tag;
  logic [SW-1:0] rd_link;

  req_t          req;
  logic [15:0]   limit, maxsz;
  logic [SW-1:0] head, tail, fhead, init_idx;
  logic [CW-1:0] count, idx;
  logic [15:0]   bytes;
  logic          found;
  logic [SW-1:0] cur, prev, pick, pick_prev, pick_next;
  logic [30:0]   pick_type;
  logic [15:0]   pick_size;
  logic [31:0]   pick_tag;
  result_t       res, res_next;

  logic [SW-1:0] raddr, waddr, wlink;
  logic          link_we;
  logic          sel_neg, sel_zero;
  logic [31:0]   neg_bound;
  logic          send_invalid, send_nospace, send_full;
  logic          rx_nomsg, rx_toobig, take;
  logic [15:0]   deliver;
  logic [16:0]   send_sum;

  assign sel_neg   = req.type_value[31];
  assign sel_zero  = (req.type_value == 32'sd0);
  assign neg_bound = ~req.type_value + 32'd1;

  assign send_sum     = {1'b0, req.byte_size} + {1'b0, bytes};
  assign send_invalid = (req.byte_size > maxsz) || sel_neg || sel_zero;
  assign send_nospace = send_sum > {1'b0, limit};
  assign send_full    = (count == FULL_COUNT);

  assign rx_nomsg  = !found || (sel_neg && ({1'b0, pick_type} > neg_bound));
  assign rx_toobig = (req.byte_size < pick_size) && !req.no_error;
  assign deliver   = (req.byte_size < pick_size) ? req.byte_size : pick_size;

  // candidate test for the entry read this cycle
  always_comb begin
    if (sel_zero) begin
      take = !found;
    end else if (!sel_neg) begin
      take = !found && ((rd_type != req.type_value[30:0]) == req.except_mode);
    end else begin
      take = !found || (rd_type < pick_type);
    end
  end

  always_comb begin
    if (cmd.s_check) begin
      raddr = fhead;
    end else if (cmd.r_start) begin
      raddr = head;
    end else begin
      raddr = rd_link;
    end
  end

  always_comb begin
    link_we = 1'b0;
    waddr = init_idx;
    wlink = (init_idx == LAST_SLOT) ? '0 : init_idx + SW'(1);
    if (cmd.init) begin
      link_we = 1'b1;
    end else if (cmd.s_wr1) begin
      link_we = 1'b1;
      waddr = fhead;
      wlink = '0;
    end else if (cmd.s_wr2) begin
      link_we = (count != '0);
      waddr = tail;
      wlink = pick;
    end else if (cmd.r_decide) begin
      link_we = !rx_nomsg && !rx_toobig && (pick != head);
      waddr = pick_prev;
      wlink = pick_next;
    end else if (cmd.r_free) begin
      link_we = 1'b1;
      waddr = pick;
      wlink = fhead;
    end
  end

  always_ff @(posedge clk) begin
    rd_type <= type_mem[raddr];
    rd_size <= size_mem[raddr];
    rd_tag  <= tag_mem[raddr];
    rd_link <= link_mem[raddr];
    if (link_we) link_mem[waddr] <= wlink;
    if (cmd.s_wr1) begin
      type_mem[fhead] <= req.type_value[30:0];
      size_mem[fhead] <= req.byte_size;
      tag_mem[fhead]  <= req.payload_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit    <= QUEUE_BYTE_LIMIT_RESET;
      maxsz    <= MAX_MESSAGE_SIZE_RESET;
      head     <= '0;
      tail     <= '0;
      fhead    <= '0;
      count    <= '0;
      bytes    <= '0;
      init_idx <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_QUEUE_BYTE_LIMIT) limit <= cfg_data;
        else maxsz <= cfg_data;
      end
      if (cmd.init) init_idx <= init_idx + SW'(1);
      if (cmd.s_wr1) fhead <= rd_link;
      if (cmd.s_wr2) begin
        if (count == '0) head <= pick;
        tail  <= pick;
        count <= count + CW'(1);
        bytes <= bytes + req.byte_size;
      end
      if (cmd.r_decide && !rx_nomsg && !rx_toobig) begin
        if (pick == head) begin
          head <= pick_next;
        end else if (pick == tail) begin
          tail <= pick_prev;
        end
      end
      if (cmd.r_free) begin
        fhead <= pick;
        count <= count - CW'(1);
        bytes <= (bytes >= pick_size) ? bytes - pick_size : '0;
        if (count == CW'(1)) begin
          head <= '0;
          tail <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) req <= request;
    if (cmd.s_wr1) pick <= fhead;
    if (cmd.r_start) begin
      idx   <= '0;
      found <= 1'b0;
      cur   <= head;
      prev  <= '0;
    end
    if (cmd.r_scan) begin
      idx  <= idx + CW'(1);
      prev <= cur;
      cur  <= rd_link;
      if (take) begin
        found     <= 1'b1;
        pick      <= cur;
        pick_prev <= prev;
        pick_next <= rd_link;
        pick_type <= rd_type;
        pick_size <= rd_size;
        pick_tag  <= rd_tag;
      end
    end
  end

  // result register
  always_comb begin
    res_next = res;
    if (cmd.s_check) begin
      res_next = '0;
      if (send_invalid) res_next.status = ST_INVALID;
      else if (send_nospace) res_next.status = ST_NOSPACE;
      else res_next.status = ST_FULL;
      res_next.message_count = 7'(count);
      res_next.bytes_held    = bytes;
    end
    if (cmd.s_wr2) begin
      res_next = '0;
      res_next.status        = ST_OK;
      res_next.length        = req.byte_size;
      res_next.message_count = 7'(count + CW'(1));
      res_next.bytes_held    = bytes + req.byte_size;
    end
    if (cmd.r_start) begin
      res_next = '0;
      res_next.status        = ST_NOMSG;
      res_next.message_count = 7'(count);
      res_next.bytes_held    = bytes;
    end
    if (cmd.r_decide) begin
      res_next = '0;
      res_next.status        = rx_nomsg ? ST_NOMSG : ST_TOOBIG;
      res_next.message_count = 7'(count);
      res_next.bytes_held    = bytes;
    end
    if (cmd.r_free) begin
      res_next.status        = ST_OK;
      res_next.length        = deliver;
      res_next.taken_type    = pick_type;
      res_next.taken_tag     = pick_tag;
      res_next.message_count = 7'(count - CW'(1));
      res_next.bytes_held    = (bytes >= pick_size) ? bytes - pick_size : '0;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  assign stat.init_last = (init_idx == LAST_SLOT);
  assign stat.opcode    = req.opcode;
  assign stat.send_bad  = send_invalid || send_nospace || send_full;
  assign stat.empty     = (count == '0);
  assign stat.scan_last = ((idx + CW'(1)) == count);
  assign stat.rx_bad    = rx_nomsg || rx_toobig;
  assign result = res;

endmodule

[design/typed_message_queue.sv]
// Typed message queue: send appends a descriptor, receive takes one out by type.
// After reset the block chains every descriptor slot into the free list and
// holds busy high meanwhile; configuration writes are taken at any time. A
// receive walks all held descriptors one per cycle through the descriptor
// memory's read port. One request is worked on at a time; done is high for
// a single cycle, and the result stays in its register until the next
// request starts. Neither can be held off.
module typed_message_queue #(
  parameter int MAX_MESSAGES = tmq_pkg::MAX_MESSAGES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  tmq_pkg::req_t    request,
  output logic             done,
  output tmq_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [15:0]      cfg_data
);
  import tmq_pkg::*;

  tmq_cmd_t  cmd;
  tmq_stat_t stat;

  assign cfg_ready = 1'b1;

  tmq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .stat  (stat)
  );

  tmq_datapath #(
    .MAX_MESSAGES (MAX_MESSAGES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

endmodule

[design/tmq_checker.sv]
// Port-level checks of the typed message queue, bound to the top level.
module tmq_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input tmq_pkg::result_t result
);
  import tmq_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not make the block busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("done without a request in progress");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status <= ST_FULL))
    else $error("status code out of range");

  a_error_clear: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_OK) |->
      (result.length == '0 && result.taken_tag == '0 && result.taken_type == '0))
    else $error("error result carries data");

endmodule

bind typed_message_queue tmq_checker u_tmq_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

[test/typed_message_queue_test.sv]
// Testbench for the typed message queue: directed and random requests, checked by a predictor.
`timescale 1ns / 100ps

module typed_message_queue_test;
  import tmq_pkg::*;

  localparam int SLOTS = 64;
  localparam int SETTLE = SLOTS + 10;

  typedef struct {
    logic [30:0] kind;
    logic [15:0] size;
    logic [31:0] tag;
  } descriptor_t;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  req_t    request;
  logic    done;
  result_t result;
  logic    cfg_valid;
  logic    cfg_ready;
  logic    cfg_index;
  logic [15:0] cfg_data;

  descriptor_t held_messages[$];
  result_t     pending_results[$];
  logic [15:0] byte_limit;
  logic [15:0] size_limit;
  logic [15:0] bytes_now;
  int          errors;
  bit          quiet;

  typed_message_queue u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Work out the result of one request and advance the queue copy.
  function automatic result_t queue_step(req_t r);
    result_t o;
    longint sel;
    int pick;
    longint t;
    o = '0;
    sel = longint'(r.type_value);
    if (r.opcode == OP_SEND) begin
      if (r.byte_size > size_limit || sel < 1) begin
        o.status = ST_INVALID;
      end else if (32'(r.byte_size) + 32'(bytes_now) > 32'(byte_limit)) begin
        o.status = ST_NOSPACE;
      end else if (held_messages.size() >= SLOTS) begin
        o.status = ST_FULL;
      end else begin
        held_messages.push_back('{r.type_value[30:0], r.byte_size, r.payload_tag});
        bytes_now += r.byte_size;
        o.status = ST_OK;
        o.length = r.byte_size;
      end
    end else begin
      pick = -1;
      foreach (held_messages[i]) begin
        t = longint'(held_messages[i].kind);
        if (sel == 0) begin
          if (pick < 0) pick = i;
        end else if (sel > 0) begin
          if (pick < 0 && ((t != sel) == r.except_mode)) pick = i;
        end else begin
          if (pick < 0 || t < longint'(held_messages[pick].kind)) pick = i;
        end
      end
      if (pick >= 0 && sel < 0 && longint'(held_messages[pick].kind) > -sel) pick = -1;
      if (pick < 0) begin
        o.status = ST_NOMSG;
      end else if (r.byte_size < held_messages[pick].size && !r.no_error) begin
        o.status = ST_TOOBIG;
      end else begin
        o.status = ST_OK;
        o.length = (r.byte_size < held_messages[pick].size) ? r.byte_size
                                                             : held_messages[pick].size;
        o.taken_type = held_messages[pick].kind;
        o.taken_tag = held_messages[pick].tag;
        bytes_now = (bytes_now >= held_messages[pick].size) ?
                    bytes_now - held_messages[pick].size : 16'd0;
        held_messages.delete(pick);
      end
    end
    o.message_count = 7'(held_messages.size());
    o.bytes_held = bytes_now;
    return o;
  endfunction

  // Check every done strobe against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %p", $time, result);
      end else begin
        want = pending_results.pop_front();
        if (result.status !== want.status || result.length !== want.length ||
            result.taken_type !== want.taken_type || result.taken_tag !== want.taken_tag ||
            result.message_count !== want.message_count ||
            result.bytes_held !== want.bytes_held) begin
          errors++;
          $display("%0t: mismatch expected %p actual %p", $time, want, result);
        end
      end
    end
  end

  task automatic idle_gap();
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 5);
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic issue(req_t r);
    idle_gap();
    @(negedge clk);
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    pending_results.push_back(queue_step(r));
  endtask

  task automatic send_msg(int kind, int size, logic [31:0] tag);
    req_t r;
    r = '0;
    r.opcode = OP_SEND;
    r.type_value = kind;
    r.byte_size = 16'(size);
    r.payload_tag = tag;
    issue(r);
  endtask

  task automatic receive_msg(int sel, int buffer, bit except, bit noerr);
    req_t r;
    r = '0;
    r.opcode = OP_RECEIVE;
    r.type_value = sel;
    r.byte_size = 16'(buffer);
    r.payload_tag = $urandom;
    r.except_mode = except;
    r.no_error = noerr;
    issue(r);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_QUEUE_BYTE_LIMIT) byte_limit = value;
    else size_limit = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic empty_queue();
    while (held_messages.size() > 0) receive_msg(0, 16'hFFFF, 1'b0, 1'b0);
  endtask

  task automatic test_directed();
    receive_msg(0, 10, 0, 0);
    send_msg(0, 5, 32'h1);
    send_msg(-7, 5, 32'h2);
    send_msg(3, 4057, 32'h3);
    send_msg(3, 4056, 32'hFFFF_FFFF);
    send_msg(32'h7FFF_FFFF, 0, 32'h0);
    send_msg(2, 100, 32'hA5A5_5A5A);
    send_msg(3, 50, 32'h1234_5678);
    receive_msg(2, 100, 0, 0);
    receive_msg(3, 10, 1, 0);
    receive_msg(3, 10, 0, 0);
    receive_msg(3, 10, 0, 1);
    receive_msg(-1, 9999, 0, 0);
    receive_msg(-3, 9999, 0, 0);
    receive_msg(-32'h7FFF_FFFF, 0, 0, 0);
    receive_msg(9, 65535, 0, 0);
    receive_msg(0, 0, 1, 1);
    receive_msg(0, 65535, 0, 0);
  endtask

  task automatic test_limits();
    write_reg(REG_MAX_MESSAGE_SIZE, 16'hFFFF);
    write_reg(REG_QUEUE_BYTE_LIMIT, 16'hFFFF);
    send_msg(1, 65535, 32'h55);
    send_msg(1, 1, 32'h66);
    empty_queue();
    for (int i = 0; i < SLOTS; i++) send_msg(1 + i % 5, 10, i);
    send_msg(1, 10, 32'h77);
    send_msg(1, 65535, 32'h78);
    receive_msg(-2, 100, 0, 0);
    receive_msg(4, 100, 1, 0);
    drain();
    write_reg(REG_QUEUE_BYTE_LIMIT, 16'd100);
    send_msg(1, 0, 32'h79);
    receive_msg(0, 100, 0, 0);
    empty_queue();
    write_reg(REG_QUEUE_BYTE_LIMIT, 16'd0);
    write_reg(REG_MAX_MESSAGE_SIZE, 16'd0);
    send_msg(1, 0, 32'h7A);
    send_msg(1, 1, 32'h7B);
    empty_queue();
  endtask

  task automatic random_item();
    req_t r;
    bit want_send;
    r.opcode = OP_SEND;
    r.payload_tag = $urandom;
    r.except_mode = 1'($urandom_range(0, 1));
    r.no_error = 1'($urandom_range(0, 1));
    want_send = (held_messages.size() < 30) ? ($urandom_range(0, 99) < 60)
                                            : ($urandom_range(0, 99) < 40);
    r.opcode = want_send ? OP_SEND : OP_RECEIVE;
    case ($urandom_range(0, 9))
      0: r.type_value = $urandom;
      1: r.type_value = -$signed($urandom_range(1, 12));
      default: r.type_value = want_send ? $urandom_range(1, 8) : $urandom_range(0, 9);
    endcase
    if (r.type_value == 32'sh8000_0000) r.type_value = 0;
    if (!want_send && $urandom_range(0, 2) == 0) r.type_value = -$signed($urandom_range(1, 9));
    case ($urandom_range(0, 9))
      0: r.byte_size = 16'($urandom);
      1: r.byte_size = 16'($urandom_range(0, 4100));
      default: r.byte_size = 16'($urandom_range(0, 600));
    endcase
    issue(r);
  endtask

  task automatic test_random();
    int settings[5][2];
    settings = '{'{16384, 4056}, '{65535, 65535}, '{3000, 800}, '{1, 1}, '{20000, 4096}};
    for (int p = 0; p < 5; p++) begin
      write_reg(REG_QUEUE_BYTE_LIMIT, 16'(settings[p][0]));
      write_reg(REG_MAX_MESSAGE_SIZE, 16'(settings[p][1]));
      // Drop the budget to zero so that a one-byte send hits the no-space path.
      if (p == 2) begin
        write_reg(REG_QUEUE_BYTE_LIMIT, 16'd0);
        send_msg(1, 1, 32'h7C);
        write_reg(REG_QUEUE_BYTE_LIMIT, 16'(settings[p][0]));
      end
      if (p == 4) quiet = 1'b1;
      for (int i = 0; i < 370; i++) random_item();
      if (p == 1) begin
        empty_queue();
        drain();
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_QUEUE_BYTE_LIMIT;
    cfg_data = '0;
    byte_limit = QUEUE_BYTE_LIMIT_RESET;
    size_limit = MAX_MESSAGE_SIZE_RESET;
    bytes_now = '0;
    errors = 0;
    quiet = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_limits();
    test_random();
    @(negedge clk);
    start <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
